// File: rtl/pmlru_pkg.sv
package pmlru_pkg;

  localparam int NUM_SLOTS      = 18;
  localparam int PAGES_PER_SLOT = 32;
  localparam int NUM_FRAMES     = 256;
  localparam int PAGE_BYTES     = 1024;

  localparam int SLOT_W     = 5;
  localparam int PAGE_W     = $clog2(PAGES_PER_SLOT);
  localparam int FRAME_W    = $clog2(NUM_FRAMES);
  localparam int PAGE_SHIFT = $clog2(PAGE_BYTES);
  localparam int ADDR_W     = 15;
  localparam int NS_W       = 30;
  localparam int SEC_W      = 32;
  localparam int CNT_W      = 32;
  localparam int STAMP_W    = SEC_W + NS_W;
  localparam int MAP_DEPTH  = NUM_SLOTS * PAGES_PER_SLOT;
  localparam int MAP_AW     = SLOT_W + PAGE_W;
  localparam int MAP_W      = FRAME_W + 1;

  localparam logic [30:0] NS_PER_SEC   = 31'd1000000000;
  localparam logic [30:0] NS_PER_2SEC  = 31'd2000000000;

  localparam logic [1:0] OP_ACCESS  = 2'd0;
  localparam logic [1:0] OP_RELEASE = 2'd1;
  localparam logic [1:0] OP_TICK    = 2'd2;

  localparam logic [1:0] CFG_HIT   = 2'd0;
  localparam logic [1:0] CFG_FAULT = 2'd1;
  localparam logic [1:0] CFG_WB    = 2'd2;
  localparam logic [1:0] CFG_TICK  = 2'd3;

  typedef struct packed {
    logic [1:0]        op;
    logic [SLOT_W-1:0] slot;
    logic [ADDR_W-1:0] address;
    logic              is_write;
  } req_t;

  typedef struct packed {
    logic [FRAME_W-1:0] frame;
    logic               hit;
    logic               evicted;
    logic               wrote_back;
    logic [SLOT_W-1:0]  victim_slot;
    logic [PAGE_W-1:0]  victim_page;
    logic [SEC_W-1:0]   clock_seconds;
    logic [NS_W-1:0]    clock_nanos;
    logic [CNT_W-1:0]   access_count;
    logic [CNT_W-1:0]   fault_count;
  } res_t;

  typedef enum logic [3:0] {
    ST_CLEAR, ST_IDLE, ST_LOOKUP, ST_SCAN, ST_WB, ST_FILL, ST_RELEASE, ST_TICK, ST_RESPOND
  } state_t;

  typedef enum logic [1:0] {
    CELL_NOP, CELL_FILL, CELL_TOUCH, CELL_RELEASE
  } cell_op_t;

  // broadcast command to the frame cells
  typedef struct packed {
    cell_op_t           kind;
    logic [FRAME_W-1:0] idx;
    logic [SLOT_W-1:0]  slot;
    logic [PAGE_W-1:0]  page;
    logic               dirty;
    logic [STAMP_W-1:0] stamp;
  } cmd_t;

  // search token moving down the chain
  typedef struct packed {
    logic               valid;
    logic               has_free;
    logic [FRAME_W-1:0] free_idx;
    logic [FRAME_W-1:0] best_idx;
    logic [STAMP_W-1:0] best_stamp;
    logic [SLOT_W-1:0]  best_owner;
    logic [PAGE_W-1:0]  best_page;
    logic               best_dirty;
  } tok_t;

  function automatic logic [STAMP_W-1:0] clk_adv(input logic [SEC_W-1:0] sec,
                                                 input logic [NS_W-1:0] ns,
                                                 input logic [NS_W-1:0] add);
    logic [30:0] tot;
    logic [30:0] rem;
    tot = {1'b0, ns} + {1'b0, add};
    if (tot >= NS_PER_2SEC) begin
      rem = tot - NS_PER_2SEC;
      return {sec + 32'd2, rem[NS_W-1:0]};
    end else if (tot >= NS_PER_SEC) begin
      rem = tot - NS_PER_SEC;
      return {sec + 32'd1, rem[NS_W-1:0]};
    end
    return {sec, tot[NS_W-1:0]};
  endfunction

  function automatic logic [CNT_W-1:0] sat_inc(input logic [CNT_W-1:0] v);
    return (v == '1) ? v : v + 1'b1;
  endfunction

endpackage

// File: rtl/paged_memory_lru_manager.sv
// a fault walks the search token one frame cell per cycle across 256 cells, then fills;
//   a write-back step comes first when the victim is dirty; a release sweeps the slot's page entries
// throughput: one command at a time, next start taken the cycle after done
// reset: synchronous; after rst the page table is swept with busy high
// the receiver cannot stall: each result shows for one cycle with done
module paged_memory_lru_manager (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  output logic                          busy,
  input  pmlru_pkg::req_t               req,
  output logic                          done,
  output pmlru_pkg::res_t               res,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [1:0]                    cfg_index,
  input  logic [pmlru_pkg::NS_W-1:0]    cfg_data
);

  // config registers
  logic [pmlru_pkg::NS_W-1:0] hit_time_ns;
  logic [pmlru_pkg::NS_W-1:0] fault_time_ns;
  logic [pmlru_pkg::NS_W-1:0] writeback_time_ns;
  logic [pmlru_pkg::NS_W-1:0] tick_time_ns;

  pmlru_pkg::state_t state, state_next;

  // latched command
  logic [1:0]                    op_q;
  logic [pmlru_pkg::SLOT_W-1:0]  slot_q;
  logic [pmlru_pkg::PAGE_W-1:0]  page_q;
  logic                          wr_q;

  // simulated clock
  logic [pmlru_pkg::SEC_W-1:0]   clk_sec;
  logic [pmlru_pkg::NS_W-1:0]    clk_ns;

  // per-slot counters
  logic [pmlru_pkg::CNT_W-1:0]   accesses [pmlru_pkg::NUM_SLOTS];
  logic [pmlru_pkg::CNT_W-1:0]   faults   [pmlru_pkg::NUM_SLOTS];

  // result registers
  logic [pmlru_pkg::FRAME_W-1:0] r_frame;
  logic                          r_hit;
  logic                          r_evicted;
  logic                          r_wb;
  logic [pmlru_pkg::SLOT_W-1:0]  r_vslot;
  logic [pmlru_pkg::PAGE_W-1:0]  r_vpage;
  logic [pmlru_pkg::CNT_W-1:0]   r_acc;
  logic [pmlru_pkg::CNT_W-1:0]   r_flt;

  // sweep counter for page table clearing
  logic [pmlru_pkg::MAP_AW-1:0]  cnt;

  // page table memory
  logic                          map_we;
  logic [pmlru_pkg::MAP_AW-1:0]  map_waddr;
  logic [pmlru_pkg::MAP_W-1:0]   map_wdata;
  logic [pmlru_pkg::MAP_AW-1:0]  map_raddr;
  logic [pmlru_pkg::MAP_W-1:0]   map_rdata;

  // frame cell chain
  pmlru_pkg::cmd_t               cmd;
  pmlru_pkg::tok_t               tok [pmlru_pkg::NUM_FRAMES+1];
  pmlru_pkg::tok_t               tok_last;
  logic                          launch;

  logic                          accept;
  logic                          req_slot_ok;
  logic                          map_hit;
  logic [pmlru_pkg::PAGE_W-1:0]  req_page;

  assign accept      = start && !busy;
  assign req_slot_ok = req.slot < pmlru_pkg::SLOT_W'(pmlru_pkg::NUM_SLOTS);
  assign req_page    = req.address[pmlru_pkg::PAGE_SHIFT +: pmlru_pkg::PAGE_W];
  assign map_hit     = map_rdata[pmlru_pkg::FRAME_W];
  assign tok_last    = tok[pmlru_pkg::NUM_FRAMES];
  assign cfg_ready   = 1'b1;

  // page table lookup is issued straight off the request
  assign map_raddr   = {req.slot, req_page};

  pmlru_ram #(
    .WIDTH(pmlru_pkg::MAP_W),
    .DEPTH(pmlru_pkg::MAP_DEPTH)
  ) u_map (
    .clk   (clk),
    .we    (map_we),
    .waddr (map_waddr),
    .wdata (map_wdata),
    .raddr (map_raddr),
    .rdata (map_rdata)
  );

  // token entering the first cell
  always_comb begin
    tok[0]       = '0;
    tok[0].valid = launch;
  end

  for (genvar g = 0; g < pmlru_pkg::NUM_FRAMES; g++) begin : g_cell
    pmlru_cell #(.IDX(g)) u_cell (
      .clk     (clk),
      .rst     (rst),
      .cmd     (cmd),
      .tok_in  (tok[g]),
      .tok_out (tok[g+1])
    );
  end

  // config transfer
  always_ff @(posedge clk) begin
    if (rst) begin
      hit_time_ns       <= 30'd100;
      fault_time_ns     <= 30'd14000000;
      writeback_time_ns <= 30'd10000000;
      tick_time_ns      <= 30'd1000;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        pmlru_pkg::CFG_HIT:   hit_time_ns       <= cfg_data;
        pmlru_pkg::CFG_FAULT: fault_time_ns     <= cfg_data;
        pmlru_pkg::CFG_WB:    writeback_time_ns <= cfg_data;
        pmlru_pkg::CFG_TICK:  tick_time_ns      <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= pmlru_pkg::ST_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  // next state
  always_comb begin
    state_next = state;
    case (state)
      pmlru_pkg::ST_CLEAR: begin
        if (cnt == pmlru_pkg::MAP_AW'(pmlru_pkg::MAP_DEPTH - 1)) state_next = pmlru_pkg::ST_IDLE;
      end
      pmlru_pkg::ST_IDLE: begin
        if (accept) begin
          case (req.op)
            pmlru_pkg::OP_ACCESS: begin
              state_next = req_slot_ok ? pmlru_pkg::ST_LOOKUP : pmlru_pkg::ST_RESPOND;
            end
            pmlru_pkg::OP_RELEASE: begin
              state_next = req_slot_ok ? pmlru_pkg::ST_RELEASE : pmlru_pkg::ST_RESPOND;
            end
            pmlru_pkg::OP_TICK: state_next = pmlru_pkg::ST_TICK;
            default:            state_next = pmlru_pkg::ST_RESPOND;
          endcase
        end
      end
      pmlru_pkg::ST_LOOKUP: begin
        state_next = map_hit ? pmlru_pkg::ST_RESPOND : pmlru_pkg::ST_SCAN;
      end
      pmlru_pkg::ST_SCAN: begin
        if (tok_last.valid) begin
          state_next = (!tok_last.has_free && tok_last.best_dirty) ? pmlru_pkg::ST_WB
                                                                   : pmlru_pkg::ST_FILL;
        end
      end
      pmlru_pkg::ST_WB:   state_next = pmlru_pkg::ST_FILL;
      pmlru_pkg::ST_FILL: state_next = pmlru_pkg::ST_RESPOND;
      pmlru_pkg::ST_RELEASE: begin
        if (cnt == pmlru_pkg::MAP_AW'(pmlru_pkg::PAGES_PER_SLOT - 1)) begin
          state_next = pmlru_pkg::ST_RESPOND;
        end
      end
      pmlru_pkg::ST_TICK:    state_next = pmlru_pkg::ST_RESPOND;
      pmlru_pkg::ST_RESPOND: state_next = pmlru_pkg::ST_IDLE;
      default:               state_next = pmlru_pkg::ST_IDLE;
    endcase
  end

  // control outputs
  always_comb begin
    busy       = (state != pmlru_pkg::ST_IDLE);
    done       = (state == pmlru_pkg::ST_RESPOND);
    map_we     = 1'b0;
    map_waddr  = cnt;
    map_wdata  = '0;
    launch     = 1'b0;
    cmd        = '0;
    cmd.kind   = pmlru_pkg::CELL_NOP;
    cmd.slot   = slot_q;
    cmd.page   = page_q;
    cmd.dirty  = wr_q;
    cmd.stamp  = {clk_sec, clk_ns};
    case (state)
      pmlru_pkg::ST_CLEAR: begin
        map_we = 1'b1;
      end
      pmlru_pkg::ST_LOOKUP: begin
        if (map_hit) begin
          // hit: restamp and mark dirty on a write
          cmd.kind = pmlru_pkg::CELL_TOUCH;
          cmd.idx  = map_rdata[pmlru_pkg::FRAME_W-1:0];
        end else begin
          launch = 1'b1;
        end
      end
      pmlru_pkg::ST_SCAN: begin
        // unmap the victim's page
        if (tok_last.valid && !tok_last.has_free) begin
          map_we    = 1'b1;
          map_waddr = {tok_last.best_owner, tok_last.best_page};
        end
      end
      pmlru_pkg::ST_FILL: begin
        map_we    = 1'b1;
        map_waddr = {slot_q, page_q};
        map_wdata = {1'b1, r_frame};
        cmd.kind  = pmlru_pkg::CELL_FILL;
        cmd.idx   = r_frame;
      end
      pmlru_pkg::ST_RELEASE: begin
        map_we    = 1'b1;
        map_waddr = {slot_q, cnt[pmlru_pkg::PAGE_W-1:0]};
        if (cnt == '0) cmd.kind = pmlru_pkg::CELL_RELEASE;
      end
      default: ;
    endcase
  end

  // sweep counter runs only in the clearing states
  always_ff @(posedge clk) begin
    if (rst) begin
      cnt <= '0;
    end else if ((state == pmlru_pkg::ST_CLEAR || state == pmlru_pkg::ST_RELEASE)
                 && state_next == state) begin
      cnt <= cnt + 1'b1;
    end else begin
      cnt <= '0;
    end
  end

  // simulated clock
  always_ff @(posedge clk) begin
    if (rst) begin
      clk_sec <= '0;
      clk_ns  <= '0;
    end else begin
      case (state)
        pmlru_pkg::ST_LOOKUP: begin
          if (map_hit) {clk_sec, clk_ns} <= pmlru_pkg::clk_adv(clk_sec, clk_ns, hit_time_ns);
        end
        pmlru_pkg::ST_WB: begin
          {clk_sec, clk_ns} <= pmlru_pkg::clk_adv(clk_sec, clk_ns, writeback_time_ns);
        end
        pmlru_pkg::ST_FILL: begin
          {clk_sec, clk_ns} <= pmlru_pkg::clk_adv(clk_sec, clk_ns, fault_time_ns);
        end
        pmlru_pkg::ST_TICK: begin
          {clk_sec, clk_ns} <= pmlru_pkg::clk_adv(clk_sec, clk_ns, tick_time_ns);
        end
        default: ;
      endcase
    end
  end

  // per-slot counters, saturating
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < pmlru_pkg::NUM_SLOTS; i++) begin
        accesses[i] <= '0;
        faults[i]   <= '0;
      end
    end else begin
      case (state)
        pmlru_pkg::ST_LOOKUP: begin
          if (map_hit) accesses[slot_q] <= pmlru_pkg::sat_inc(accesses[slot_q]);
        end
        pmlru_pkg::ST_FILL: begin
          accesses[slot_q] <= pmlru_pkg::sat_inc(accesses[slot_q]);
          faults[slot_q]   <= pmlru_pkg::sat_inc(faults[slot_q]);
        end
        pmlru_pkg::ST_RELEASE: begin
          if (state_next != state) begin
            accesses[slot_q] <= '0;
            faults[slot_q]   <= '0;
          end
        end
        default: ;
      endcase
    end
  end

  // command latch and result fields
  always_ff @(posedge clk) begin
    if (accept) begin
      op_q      <= req.op;
      slot_q    <= req.slot;
      page_q    <= req_page;
      wr_q      <= req.is_write;
      r_frame   <= '0;
      r_hit     <= 1'b0;
      r_evicted <= 1'b0;
      r_wb      <= 1'b0;
      r_vslot   <= '0;
      r_vpage   <= '0;
      // release reports the counts before clearing
      if (req.op == pmlru_pkg::OP_RELEASE && req_slot_ok) begin
        r_acc <= accesses[req.slot];
        r_flt <= faults[req.slot];
      end else begin
        r_acc <= '0;
        r_flt <= '0;
      end
    end else begin
      case (state)
        pmlru_pkg::ST_LOOKUP: begin
          if (map_hit) begin
            r_frame <= map_rdata[pmlru_pkg::FRAME_W-1:0];
            r_hit   <= 1'b1;
            r_acc   <= pmlru_pkg::sat_inc(accesses[slot_q]);
            r_flt   <= faults[slot_q];
          end
        end
        pmlru_pkg::ST_SCAN: begin
          if (tok_last.valid) begin
            if (tok_last.has_free) begin
              r_frame <= tok_last.free_idx;
            end else begin
              r_frame   <= tok_last.best_idx;
              r_evicted <= 1'b1;
              r_wb      <= tok_last.best_dirty;
              r_vslot   <= tok_last.best_owner;
              r_vpage   <= tok_last.best_page;
            end
          end
        end
        pmlru_pkg::ST_FILL: begin
          r_acc <= pmlru_pkg::sat_inc(accesses[slot_q]);
          r_flt <= pmlru_pkg::sat_inc(faults[slot_q]);
        end
        default: ;
      endcase
    end
  end

  // result transfer; the latched op zeroes the counts for a tick
  always_comb begin
    res               = '0;
    res.frame         = r_frame;
    res.hit           = r_hit;
    res.evicted       = r_evicted;
    res.wrote_back    = r_wb;
    res.victim_slot   = r_vslot;
    res.victim_page   = r_vpage;
    res.clock_seconds = clk_sec;
    res.clock_nanos   = clk_ns;
    res.access_count  = (op_q == pmlru_pkg::OP_TICK) ? '0 : r_acc;
    res.fault_count   = (op_q == pmlru_pkg::OP_TICK) ? '0 : r_flt;
  end

endmodule

// File: rtl/pmlru_ram.sv
module pmlru_ram #(
  parameter int WIDTH = 9,
  parameter int DEPTH = 576
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// File: rtl/pmlru_cell.sv
module pmlru_cell #(
  parameter int IDX = 0
) (
  input  logic             clk,
  input  logic             rst,
  input  pmlru_pkg::cmd_t  cmd,
  input  pmlru_pkg::tok_t  tok_in,
  output pmlru_pkg::tok_t  tok_out
);

  logic                               used;
  logic                               dirty;
  logic [pmlru_pkg::SLOT_W-1:0]       owner;
  logic [pmlru_pkg::PAGE_W-1:0]       page;
  logic [pmlru_pkg::STAMP_W-1:0]      stamp;
  logic                               sel;
  pmlru_pkg::tok_t                    tok_next;

  assign sel = (cmd.idx == pmlru_pkg::FRAME_W'(IDX));

  always_ff @(posedge clk) begin
    if (rst) begin
      used  <= 1'b0;
      dirty <= 1'b0;
    end else begin
      case (cmd.kind)
        pmlru_pkg::CELL_FILL: begin
          if (sel) begin
            used  <= 1'b1;
            dirty <= cmd.dirty;
          end
        end
        pmlru_pkg::CELL_TOUCH: begin
          if (sel && cmd.dirty) begin
            dirty <= 1'b1;
          end
        end
        pmlru_pkg::CELL_RELEASE: begin
          if (used && owner == cmd.slot) begin
            used  <= 1'b0;
            dirty <= 1'b0;
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (sel && cmd.kind == pmlru_pkg::CELL_FILL) begin
      owner <= cmd.slot;
      page  <= cmd.page;
      stamp <= cmd.stamp;
    end else if (sel && cmd.kind == pmlru_pkg::CELL_TOUCH) begin
      stamp <= cmd.stamp;
    end
  end

  // first free frame wins; strictly older stamp takes over the victim
  always_comb begin
    tok_next = tok_in;
    if (!tok_in.has_free && !used) begin
      tok_next.has_free = 1'b1;
      tok_next.free_idx = pmlru_pkg::FRAME_W'(IDX);
    end
    if (IDX == 0 || stamp < tok_in.best_stamp) begin
      tok_next.best_idx   = pmlru_pkg::FRAME_W'(IDX);
      tok_next.best_stamp = stamp;
      tok_next.best_owner = owner;
      tok_next.best_page  = page;
      tok_next.best_dirty = dirty;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      tok_out.valid <= 1'b0;
    end else begin
      tok_out.valid <= tok_in.valid;
    end
    tok_out.has_free   <= tok_next.has_free;
    tok_out.free_idx   <= tok_next.free_idx;
    tok_out.best_idx   <= tok_next.best_idx;
    tok_out.best_stamp <= tok_next.best_stamp;
    tok_out.best_owner <= tok_next.best_owner;
    tok_out.best_page  <= tok_next.best_page;
    tok_out.best_dirty <= tok_next.best_dirty;
  end

endmodule

// File: rtl/pmlru_checker.sv
module pmlru_checker (
  input logic            clk,
  input logic            rst,
  input logic            start,
  input logic            busy,
  input logic            done,
  input pmlru_pkg::res_t res
);

  // a result only closes a command in flight
  a_done_busy: assert property (@(posedge clk) disable iff (rst) done |-> busy)
    else $error("done without busy");

  // one result per command, then free
  a_done_free: assert property (@(posedge clk) disable iff (rst) done |=> !busy && !done)
    else $error("not idle after done");

  // transfer of a command makes the block busy
  a_take: assert property (@(posedge clk) disable iff (rst) (start && !busy) |=> busy)
    else $error("start not taken");

  // a hit never replaces a frame
  a_hit_evict: assert property (@(posedge clk) disable iff (rst)
    done && res.hit |-> !res.evicted && !res.wrote_back)
    else $error("hit with eviction");

  // write-back only for a replaced frame
  a_wb_evict: assert property (@(posedge clk) disable iff (rst)
    done && res.wrote_back |-> res.evicted)
    else $error("write-back without eviction");

endmodule

bind paged_memory_lru_manager pmlru_checker u_pmlru_checker (
  .clk   (clk),
  .rst   (rst),
  .start (start),
  .busy  (busy),
  .done  (done),
  .res   (res)
);
